// ----- rtl/hexb_pkg.sv -----
// ----------------------------------------------------------------------------
// hexb_pkg
// Shared types and constants of the hex text to byte buffer.
// ----------------------------------------------------------------------------
package hexb_pkg;

  localparam int unsigned CountW = 15;  // width of the byte counter
  localparam int unsigned DataW  = 32;  // widest element value
  localparam int unsigned NumW   = 3;   // holds a byte count of 0 to 4

  // One emit job handed from the parser to the byte sequencer.
  // num_bytes of zero marks a bare completion result.
  typedef struct packed {
    logic [DataW-1:0]  data;
    logic [NumW-1:0]   num_bytes;
    logic              done;
    logic [CountW-1:0] base;
  } job_t;

endpackage

// ----- rtl/hex_text_to_byte_buffer.sv -----
// ----------------------------------------------------------------------------
// hex_text_to_byte_buffer
// Turns a command text, one character per transfer, into buffer bytes.
// ----------------------------------------------------------------------------
// Usage: characters enter on the in channel (valid/ready), one per transfer,
// with end_of_string_i on the final character. Hex tokens, size letters S/W/L
// and quoted text are parsed; each result leaves on the out channel
// (valid/ready) as one byte with its running byte count. last_of_run_o marks
// the last result of a character and string_done_o the last of the string.
// start_size_code_i is written when cfg_we_i is high; it applies from the
// next string start.
// Throughput: one character per cycle. A token produces up to four results,
// sent one per cycle by the byte sequencer while the receiver is ready; a
// four-entry job queue between the parser and the sequencer absorbs these
// bursts, and the parser drops ready only when that queue is full.
// Path: each character's job is written into the job queue, and its first
// result is then loaded from the queue into the output register.
// Reset: clears the parser, the queue pointers and the output valid flag; no
// settling time. A stalled receiver holds the output register, then fills the
// queue, then stalls the input.
// ----------------------------------------------------------------------------
module hex_text_to_byte_buffer #(
  parameter int unsigned MAX_OUT_BYTES = 32767
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  start_size_code_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [7:0]                  char_code_i,
  input  logic                        end_of_string_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  out_byte_o,
  output logic                        byte_valid_o,
  output logic                        last_of_run_o,
  output logic                        string_done_o,
  output logic [hexb_pkg::CountW-1:0] byte_count_o
);

  import hexb_pkg::*;

  localparam int unsigned QueueDepth = 4;

  job_t job_in, job_out;
  logic push, pop, empty, full;
  logic [$bits(job_t)-1:0] job_rdata;

  hexb_front #(
    .MAX_OUT_BYTES(MAX_OUT_BYTES)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .start_size_code_i(start_size_code_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .char_code_i      (char_code_i),
    .end_of_string_i  (end_of_string_i),
    .full_i           (full),
    .push_o           (push),
    .job_o            (job_in)
  );

  hexb_fifo #(
    .WIDTH($bits(job_t)),
    .DEPTH(QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(job_in),
    .pop_i  (pop),
    .rdata_o(job_rdata),
    .empty_o(empty),
    .full_o (full)
  );

  assign job_out = job_t'(job_rdata);

  hexb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (job_out),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .last_of_run_o(last_of_run_o),
    .string_done_o(string_done_o),
    .byte_count_o (byte_count_o)
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push && full))
    else $error("job queue overflow");

  a_bare_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !byte_valid_o |-> last_of_run_o && string_done_o)
    else $error("bare result not at string end");

  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && string_done_o |-> last_of_run_o)
    else $error("string end inside a run");

  a_count_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> byte_count_o <= CountW'(MAX_OUT_BYTES))
    else $error("byte count above limit");
`endif

endmodule

// ----- rtl/hexb_fifo.sv -----
// ----------------------------------------------------------------------------
// hexb_fifo
// Small register queue between the parser and the byte sequencer.
// ----------------------------------------------------------------------------
module hexb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CW'(DEPTH));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/hexb_front.sv -----
// ----------------------------------------------------------------------------
// hexb_front
// Character parser: classifies each character, tracks token state and the
// byte count, and queues one emit job per result-producing or final character.
// ----------------------------------------------------------------------------
module hexb_front #(
  parameter int unsigned MAX_OUT_BYTES = 32767
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           start_size_code_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           char_code_i,
  input  logic                 end_of_string_i,
  input  logic                 full_i,
  output logic                 push_o,
  output hexb_pkg::job_t       job_o
);

  import hexb_pkg::*;

  typedef enum logic [2:0] {
    PH_SKIP,
    PH_QUOTE,
    PH_LEAD,
    PH_DIGITS,
    PH_REST
  } phase_e;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChUpS   = 8'h53;
  localparam logic [7:0] ChLoS   = 8'h73;
  localparam logic [7:0] ChUpW   = 8'h57;
  localparam logic [7:0] ChLoW   = 8'h77;
  localparam logic [7:0] ChUpL   = 8'h4c;
  localparam logic [7:0] ChLoL   = 8'h6c;
  localparam logic [7:0] ChUpX   = 8'h58;
  localparam logic [7:0] ChLoX   = 8'h78;

  // prefix tracking: nothing yet, a leading zero, the 0x prefix, plain digits
  localparam logic [1:0] PfxNone = 2'd0;
  localparam logic [1:0] PfxZero = 2'd1;
  localparam logic [1:0] PfxX    = 2'd2;
  localparam logic [1:0] PfxDone = 2'd3;

  localparam logic [1:0] SizeByte = 2'd0;
  localparam logic [1:0] SizeWord = 2'd1;
  localparam logic [1:0] SizeLong = 2'd2;

  localparam logic [CountW-1:0] MaxBytes = CountW'(MAX_OUT_BYTES);

  logic [1:0]        start_size_q;
  phase_e            phase_q, phase_d;
  logic [1:0]        size_q, size_d;
  logic [DataW-1:0]  hex_q, hex_d;
  logic              digits_q, digits_d;
  logic [1:0]        pfx_q, pfx_d;
  logic [CountW-1:0] bytes_q, bytes_d;
  logic              open_q;

  logic [7:0]        c;
  logic [3:0]        dig;
  logic              dig_ok, is_x, do_feed, emit_quote, emit_tok, accept;
  logic [NumW-1:0]   job_n, job_k;
  logic [CountW-1:0] room;

  assign c          = char_code_i;
  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_x       = (c == ChUpX) || (c == ChLoX);

  always_comb begin
    dig    = 4'd0;
    dig_ok = 1'b1;
    if (c >= 8'h30 && c <= 8'h39) begin
      dig = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      dig = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      dig = 4'(c - 8'h37);
    end else begin
      dig_ok = 1'b0;
    end
  end

  always_comb begin
    phase_d    = phase_q;
    size_d     = open_q ? size_q : ((start_size_q == 2'd3) ? SizeLong : start_size_q);
    hex_d      = hex_q;
    digits_d   = digits_q;
    pfx_d      = pfx_q;
    do_feed    = 1'b0;
    emit_quote = 1'b0;
    emit_tok   = 1'b0;

    case (phase_q)
      PH_QUOTE: begin
        if (c == ChQuote) phase_d = PH_SKIP;
        else emit_quote = 1'b1;
      end
      PH_LEAD: begin
        if (c != ChSpace) begin
          phase_d = PH_DIGITS;
          do_feed = 1'b1;
        end
      end
      PH_DIGITS, PH_REST: begin
        if (c == ChSpace) begin
          emit_tok = 1'b1;
          phase_d  = PH_SKIP;
        end else if (phase_q == PH_DIGITS) begin
          do_feed = 1'b1;
        end
      end
      default: begin
        if (c == ChQuote) begin
          phase_d = PH_QUOTE;
        end else if (c != ChSpace) begin
          digits_d = 1'b0;
          pfx_d    = PfxNone;
          if (c == ChUpS || c == ChLoS) begin
            size_d  = SizeByte;
            phase_d = PH_LEAD;
          end else if (c == ChUpW || c == ChLoW) begin
            size_d  = SizeWord;
            phase_d = PH_LEAD;
          end else if (c == ChUpL || c == ChLoL) begin
            size_d  = SizeLong;
            phase_d = PH_LEAD;
          end else begin
            phase_d = PH_DIGITS;
            do_feed = 1'b1;
          end
        end
      end
    endcase

    if (do_feed) begin
      if (pfx_d == PfxZero && is_x) begin
        pfx_d = PfxX;
      end else if (!dig_ok) begin
        phase_d = PH_REST;
      end else begin
        if (!digits_d && pfx_d == PfxNone && dig == 4'd0) pfx_d = PfxZero;
        else if (pfx_d != PfxX) pfx_d = PfxDone;
        hex_d    = digits_d ? {hex_q[DataW-5:0], dig} : {{(DataW-4){1'b0}}, dig};
        digits_d = 1'b1;
      end
    end

    // flush an open token at the end of the string
    if (end_of_string_i &&
        (phase_d == PH_LEAD || phase_d == PH_DIGITS || phase_d == PH_REST)) begin
      emit_tok = 1'b1;
    end
  end

  always_comb begin
    if (emit_quote) job_n = NumW'(1);
    else if (!emit_tok) job_n = '0;
    else if (size_d == SizeByte) job_n = NumW'(1);
    else if (size_d == SizeWord) job_n = NumW'(2);
    else job_n = NumW'(4);
  end

  // drop whatever does not fit within the byte limit
  assign room    = MaxBytes - bytes_q;
  assign job_k   = (room < CountW'(job_n)) ? room[NumW-1:0] : job_n;
  assign bytes_d = bytes_q + CountW'(job_k);

  assign push_o          = accept && ((job_k != '0) || end_of_string_i);
  assign job_o.data      = emit_quote ? {{(DataW-8){1'b0}}, c} : hex_d;
  assign job_o.num_bytes = job_k;
  assign job_o.done      = end_of_string_i;
  assign job_o.base      = bytes_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_size_q <= 2'd0;
      phase_q      <= PH_SKIP;
      size_q       <= SizeByte;
      hex_q        <= '0;
      digits_q     <= 1'b0;
      pfx_q        <= PfxNone;
      bytes_q      <= '0;
      open_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        start_size_q <= start_size_code_i;
      end
      if (accept) begin
        if (end_of_string_i) begin
          phase_q  <= PH_SKIP;
          size_q   <= SizeByte;
          hex_q    <= '0;
          digits_q <= 1'b0;
          pfx_q    <= PfxNone;
          bytes_q  <= '0;
          open_q   <= 1'b0;
        end else begin
          phase_q  <= phase_d;
          size_q   <= size_d;
          hex_q    <= hex_d;
          digits_q <= digits_d;
          pfx_q    <= pfx_d;
          bytes_q  <= bytes_d;
          open_q   <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/hexb_back.sv -----
// ----------------------------------------------------------------------------
// hexb_back
// Byte sequencer: walks each queued job one byte per cycle into the output
// register unless the receiver stalls; marks the run and string boundaries.
// ----------------------------------------------------------------------------
module hexb_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hexb_pkg::job_t              job_i,
  input  logic                        empty_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [7:0]                  out_byte_o,
  output logic                        byte_valid_o,
  output logic                        last_of_run_o,
  output logic                        string_done_o,
  output logic [hexb_pkg::CountW-1:0] byte_count_o
);

  import hexb_pkg::*;

  logic [1:0]        idx_q;
  logic              out_valid_q;
  logic [7:0]        byte_q;
  logic              bvalid_q, run_last_q, done_q;
  logic [CountW-1:0] count_q;

  logic              load, bare, run_last;
  logic [7:0]        sel_byte;

  assign load     = !empty_i && (!out_valid_q || out_ready_i);
  assign bare     = (job_i.num_bytes == '0);
  assign run_last = bare || ({1'b0, idx_q} == job_i.num_bytes - NumW'(1));
  assign sel_byte = job_i.data[{idx_q, 3'b000} +: 8];
  assign pop_o    = load && run_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= run_last ? 2'd0 : idx_q + 2'd1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q     <= bare ? 8'd0 : sel_byte;
      bvalid_q   <= !bare;
      run_last_q <= run_last;
      done_q     <= job_i.done && run_last;
      count_q    <= bare ? job_i.base : job_i.base + CountW'(idx_q) + CountW'(1);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = byte_q;
  assign byte_valid_o  = bvalid_q;
  assign last_of_run_o = run_last_q;
  assign string_done_o = done_q;
  assign byte_count_o  = count_q;

endmodule
